// ----- rtl/dvtu_pkg.sv -----
// ----------------------------------------------------------------------------
// Distance-vector table update package
// Shared widths, result action codes and the structs passed along the chain.
// ----------------------------------------------------------------------------
package dvtu_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int ADDR_W              = 32;
    localparam int COST_W              = 8;
    localparam int INDEX_W             = 4;
    localparam int IN_DATA_W           = 104;
    localparam int OUT_DATA_W          = 80;
    localparam int ACTION_W            = 3;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REFRESH   = 3'd0,
        ACT_REPLACE   = 3'd1,
        ACT_INSERT    = 3'd2,
        ACT_UNCHANGED = 3'd3,
        ACT_DROPPED   = 3'd4
    } action_t;

    // Search token that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic              live;
        logic              found;
        logic              have_free;
        logic [ADDR_W-1:0] hit_next_hop;
        logic [ADDR_W-1:0] hit_iface;
        logic [COST_W-1:0] hit_cost;
    } search_tok_t;

    // Write-back broadcast to all cells; the addressed cell takes it.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] next_hop;
        logic [ADDR_W-1:0] iface;
        logic [COST_W-1:0] cost;
    } route_wr_t;

endpackage

// ----- rtl/distance_vector_table_update.sv -----
// ----------------------------------------------------------------------------
// Distance-vector routing table update
// Searches a row of route cells for an advertised or installed destination
// and writes back at most one slot, reporting that slot as one result item.
// ----------------------------------------------------------------------------
// Each item occupies the block from the cycle in which it is accepted until its
// decide step is done: the search token walks the row of cells one slot per
// cycle, starting in the acceptance cycle; the token leaving the last cell is then
// latched, and the decide step writes the chosen slot back and loads the result
// item into the output register. The decide step waits while an earlier result
// still sits unread in the output register, so a stalled output stretches the item
// by the length of that stall. One item is in work at a time; a new item is
// accepted as soon as the previous one has left the decide step, even while its
// result still waits in the output register. The table holds no routes after reset.
module distance_vector_table_update
    import dvtu_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // adv_dest, adv_cost, from_neighbor, local_interface (lowest bit first)
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // entry_index, entry_cost, entry_next_hop, entry_interface, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // action
    output logic [ACTION_W-1:0]   m_axis_tuser
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE
    } state_t;

    state_t            state_reg;
    logic              accept;
    logic              out_free;

    logic              req_install_reg;
    logic [ADDR_W-1:0] req_dest_reg;
    logic [COST_W-1:0] req_cost_reg;
    logic [ADDR_W-1:0] req_from_reg;
    logic [ADDR_W-1:0] req_iface_reg;
    logic [ADDR_W-1:0] search_dest;

    search_tok_t       tok   [TABLE_DEPTH+1];
    logic [IDX_W-1:0]  hit   [TABLE_DEPTH+1];
    logic [IDX_W-1:0]  free  [TABLE_DEPTH+1];

    search_tok_t       tail_tok_reg;
    logic [IDX_W-1:0]  tail_hit_reg;
    logic [IDX_W-1:0]  tail_free_reg;

    route_wr_t         wr;
    logic [IDX_W-1:0]  wr_slot;
    logic [IDX_W-1:0]  res_slot;
    action_t           res_action;
    logic [COST_W-1:0] res_cost;
    logic [ADDR_W-1:0] res_next_hop;
    logic [ADDR_W-1:0] res_iface;
    logic [COST_W-1:0] new_cost;
    logic [IDX_W+INDEX_W-1:0] slot_ext;

    logic              out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    action_t           out_action_reg;
    logic [COST_W-1:0] out_cost_reg;
    logic [ADDR_W-1:0] out_next_hop_reg;
    logic [ADDR_W-1:0] out_iface_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Cell 0 compares in the cycle of acceptance, before the request is held.
    assign search_dest = (state_reg == ST_IDLE) ? s_axis_tdata[31:0] : req_dest_reg;

    always_comb
    begin
        tok[0]      = '0;
        tok[0].live = accept;
        hit[0]      = '0;
        free[0]     = '0;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        dvtu_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .req_dest (search_dest),
            .tok_in   (tok[g]),
            .hit_in   (hit[g]),
            .free_in  (free[g]),
            .wr       (wr),
            .wr_slot  (wr_slot),
            .tok_out  (tok[g+1]),
            .hit_out  (hit[g+1]),
            .free_out (free[g+1])
        );
    end

    assign new_cost = (req_cost_reg == COST_MAX) ? COST_MAX : req_cost_reg + COST_W'(1);

    always_comb
    begin
        res_slot     = tail_hit_reg;
        res_action   = ACT_UNCHANGED;
        res_cost     = tail_tok_reg.hit_cost;
        res_next_hop = tail_tok_reg.hit_next_hop;
        res_iface    = tail_tok_reg.hit_iface;
        wr.en        = 1'b0;
        if (tail_tok_reg.found)
        begin
            if (req_install_reg)
            begin
                res_action   = ACT_REPLACE;
                res_cost     = '0;
                res_next_hop = req_iface_reg;
                res_iface    = req_iface_reg;
                wr.en        = 1'b1;
            end
            else if (tail_tok_reg.hit_next_hop == req_from_reg)
            begin
                res_action = ACT_REFRESH;
                res_cost   = new_cost;
                wr.en      = 1'b1;
            end
            else if (new_cost < tail_tok_reg.hit_cost)
            begin
                res_action   = ACT_REPLACE;
                res_cost     = new_cost;
                res_next_hop = req_from_reg;
                res_iface    = req_iface_reg;
                wr.en        = 1'b1;
            end
        end
        else if (!tail_tok_reg.have_free)
        begin
            res_slot     = '0;
            res_action   = ACT_DROPPED;
            res_cost     = '0;
            res_next_hop = '0;
            res_iface    = '0;
        end
        else
        begin
            res_slot   = tail_free_reg;
            res_action = ACT_INSERT;
            res_iface  = req_iface_reg;
            wr.en      = 1'b1;
            if (req_install_reg)
            begin
                res_cost     = '0;
                res_next_hop = req_iface_reg;
            end
            else
            begin
                res_next_hop = req_from_reg;
                res_cost     = (req_from_reg == req_dest_reg) ? COST_W'(1) : new_cost;
            end
        end
        // Write-back fires only in the decide cycle with room at the output.
        wr.en       = wr.en && (state_reg == ST_DECIDE) && out_free;
        wr.dest     = req_dest_reg;
        wr.next_hop = res_next_hop;
        wr.iface    = res_iface;
        wr.cost     = res_cost;
    end

    assign wr_slot  = res_slot;
    assign slot_ext = (IDX_W+INDEX_W)'(res_slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_DECIDE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (tok[TABLE_DEPTH].live)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_install_reg <= s_axis_tuser;
            req_dest_reg    <= s_axis_tdata[31:0];
            req_cost_reg    <= s_axis_tdata[39:32];
            req_from_reg    <= s_axis_tdata[71:40];
            req_iface_reg   <= s_axis_tdata[103:72];
        end
        if ((state_reg == ST_SEARCH) && tok[TABLE_DEPTH].live)
        begin
            tail_tok_reg  <= tok[TABLE_DEPTH];
            tail_hit_reg  <= hit[TABLE_DEPTH];
            tail_free_reg <= free[TABLE_DEPTH];
        end
        if ((state_reg == ST_DECIDE) && out_free)
        begin
            out_index_reg    <= slot_ext[INDEX_W-1:0];
            out_action_reg   <= res_action;
            out_cost_reg     <= res_cost;
            out_next_hop_reg <= res_next_hop;
            out_iface_reg    <= res_iface;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_action_reg;
    assign m_axis_tdata  = {4'b0000, out_iface_reg, out_next_hop_reg,
                            out_cost_reg, out_index_reg};

endmodule

// ----- rtl/dvtu_cell.sv -----
// ----------------------------------------------------------------------------
// Route cell
// Holds one table slot, updates the passing search token and takes writes.
// ----------------------------------------------------------------------------
module dvtu_cell
    import dvtu_pkg::*;
#(
    parameter int IDX_W      = 4,
    parameter int CELL_INDEX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] req_dest,
    input  search_tok_t       tok_in,
    input  logic [IDX_W-1:0]  hit_in,
    input  logic [IDX_W-1:0]  free_in,
    input  route_wr_t         wr,
    input  logic [IDX_W-1:0]  wr_slot,
    output search_tok_t       tok_out,
    output logic [IDX_W-1:0]  hit_out,
    output logic [IDX_W-1:0]  free_out
);

    localparam logic [IDX_W-1:0] SLOT = IDX_W'(CELL_INDEX);

    logic              valid_reg;
    logic [ADDR_W-1:0] dest_reg;
    logic [ADDR_W-1:0] next_hop_reg;
    logic [ADDR_W-1:0] iface_reg;
    logic [COST_W-1:0] cost_reg;

    search_tok_t       tok_reg;
    search_tok_t       tok_next;
    logic [IDX_W-1:0]  hit_reg;
    logic [IDX_W-1:0]  hit_next;
    logic [IDX_W-1:0]  free_reg;
    logic [IDX_W-1:0]  free_next;
    logic              wr_here;

    assign wr_here = wr.en && (wr_slot == SLOT);

    // The lowest matching slot wins, and so does the lowest free slot.
    always_comb
    begin
        tok_next  = tok_in;
        hit_next  = hit_in;
        free_next = free_in;
        if (tok_in.live)
        begin
            if (valid_reg)
            begin
                if (!tok_in.found && (dest_reg == req_dest))
                begin
                    tok_next.found        = 1'b1;
                    tok_next.hit_next_hop = next_hop_reg;
                    tok_next.hit_iface    = iface_reg;
                    tok_next.hit_cost     = cost_reg;
                    hit_next              = SLOT;
                end
            end
            else if (!tok_in.have_free)
            begin
                tok_next.have_free = 1'b1;
                free_next          = SLOT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr_here)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        free_reg <= free_next;
        if (wr_here)
        begin
            dest_reg     <= wr.dest;
            next_hop_reg <= wr.next_hop;
            iface_reg    <= wr.iface;
            cost_reg     <= wr.cost;
        end
    end

    assign tok_out  = tok_reg;
    assign hit_out  = hit_reg;
    assign free_out = free_reg;

endmodule

// ----- rtl/dvtu_checker.sv -----
// ----------------------------------------------------------------------------
// Distance-vector table update port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module dvtu_checker
    import dvtu_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [ACTION_W-1:0]   m_axis_tuser
);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // A stalled result item keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // Only one item is in work at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // The search runs through every cell first, so no result follows an accept directly.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !$rose(m_axis_tvalid))
        else $error("result appeared right after an accepted item");

    // A dropped destination reports an empty slot.
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ACT_DROPPED) |-> (m_axis_tdata == '0))
        else $error("dropped item carries nonzero slot data");

endmodule

bind distance_vector_table_update dvtu_checker u_dvtu_checker (.*);

// ----- tb/sv/tb_distance_vector_table_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance-vector table update testbench
// Sends advertise and install requests over the input stream and checks every
// result item against a routing table kept in step with the block. A short
// directed plan covers inserts, cost saturation, the neighbor-is-destination
// rule, refresh, replace, unchanged and a full table. Random traffic follows.
// ----------------------------------------------------------------------------
module tb_distance_vector_table_update;
    import dvtu_pkg::*;

    localparam int DEPTH      = DEFAULT_TABLE_DEPTH;
    localparam int RAND_ITEMS = 1700;
    localparam int WDOG_LIMIT = 4000;

    typedef struct packed {
        logic              install;
        logic [ADDR_W-1:0] dest;
        logic [COST_W-1:0] cost;
        logic [ADDR_W-1:0] nbr;
        logic [ADDR_W-1:0] ifc;
    } route_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        action_t            action;
        logic [COST_W-1:0]  cost;
        logic [ADDR_W-1:0]  hop;
        logic [ADDR_W-1:0]  ifc;
    } route_result_t;

    typedef struct packed {
        route_req_t    req;
        logic          fixed;
        route_result_t want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [ACTION_W-1:0]   m_axis_tuser;

    // Routing table as the block should hold it.
    logic              rt_valid [DEPTH];
    logic [ADDR_W-1:0] rt_dest  [DEPTH];
    logic [ADDR_W-1:0] rt_hop   [DEPTH];
    logic [ADDR_W-1:0] rt_ifc   [DEPTH];
    logic [COST_W-1:0] rt_cost  [DEPTH];

    route_result_t expected_routes [$];
    plan_row_t     plan [$];
    int            err_cnt = 0;
    int            idle_cycles = 0;
    int            tx_mode_left = 0;
    bit            tx_calm = 0;
    int            rx_mode_left = 0;
    bit            rx_calm = 0;
    int            rx_hold = 0;

    distance_vector_table_update i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic route_result_t apply_update(input route_req_t rq);
        route_result_t     res;
        int                i;
        int                hit;
        int                free_slot;
        bit                found;
        bit                have_free;
        logic [COST_W-1:0] c;
        found     = 0;
        have_free = 0;
        hit       = 0;
        free_slot = 0;
        res       = '0;
        c = (rq.cost == COST_MAX) ? COST_MAX : rq.cost + COST_W'(1);
        for (i = 0; i < DEPTH; i++)
        begin
            if (rt_valid[i])
            begin
                if (!found && rt_dest[i] == rq.dest)
                begin
                    found = 1;
                    hit   = i;
                end
            end
            else if (!have_free)
            begin
                have_free = 1;
                free_slot = i;
            end
        end
        if (found)
        begin
            if (rq.install)
            begin
                rt_hop[hit]  = rq.ifc;
                rt_ifc[hit]  = rq.ifc;
                rt_cost[hit] = '0;
                res.action   = ACT_REPLACE;
            end
            else if (rt_hop[hit] == rq.nbr)
            begin
                rt_cost[hit] = c;
                res.action   = ACT_REFRESH;
            end
            else if (c < rt_cost[hit])
            begin
                rt_hop[hit]  = rq.nbr;
                rt_ifc[hit]  = rq.ifc;
                rt_cost[hit] = c;
                res.action   = ACT_REPLACE;
            end
            else
            begin
                res.action = ACT_UNCHANGED;
            end
        end
        else if (have_free)
        begin
            hit           = free_slot;
            rt_valid[hit] = 1'b1;
            rt_dest[hit]  = rq.dest;
            rt_ifc[hit]   = rq.ifc;
            if (rq.install)
            begin
                rt_hop[hit]  = rq.ifc;
                rt_cost[hit] = '0;
            end
            else
            begin
                rt_hop[hit]  = rq.nbr;
                // A neighbor advertising itself is one hop away.
                rt_cost[hit] = (rq.nbr == rq.dest) ? 8'd1 : c;
            end
            res.action = ACT_INSERT;
        end
        else
        begin
            res.action = ACT_DROPPED;
        end
        if (res.action != ACT_DROPPED)
        begin
            res.index = hit[INDEX_W-1:0];
            res.cost  = rt_cost[hit];
            res.hop   = rt_hop[hit];
            res.ifc   = rt_ifc[hit];
        end
        return res;
    endfunction

    function automatic void plan_row(input logic inst, input logic [ADDR_W-1:0] d,
                                     input logic [COST_W-1:0] c,
                                     input logic [ADDR_W-1:0] n,
                                     input logic [ADDR_W-1:0] f);
        plan_row_t row;
        row             = '0;
        row.req.install = inst;
        row.req.dest    = d;
        row.req.cost    = c;
        row.req.nbr     = n;
        row.req.ifc     = f;
        plan.insert(plan.size(), row);
    endfunction

    // Pins the expected result of the row added last.
    function automatic void plan_want(input logic [INDEX_W-1:0] idx, input action_t act,
                                      input logic [COST_W-1:0] c,
                                      input logic [ADDR_W-1:0] hop,
                                      input logic [ADDR_W-1:0] f);
        int last;
        last                   = plan.size() - 1;
        plan[last].fixed       = 1'b1;
        plan[last].want.index  = idx;
        plan[last].want.action = act;
        plan[last].want.cost   = c;
        plan[last].want.hop    = hop;
        plan[last].want.ifc    = f;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(15, 60);
    endfunction

    function automatic int next_tx_gap();
        if (tx_mode_left == 0)
        begin
            tx_calm      = ($urandom_range(0, 3) == 0);
            tx_mode_left = $urandom_range(20, 80);
        end
        tx_mode_left--;
        return tx_calm ? 0 : idle_len();
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] seen,
                                   input logic [ADDR_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, seen, want);
        err_cnt++;
    endtask

    task automatic send_request(input route_req_t rq, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rq.ifc, rq.nbr, rq.cost, rq.dest};
        s_axis_tuser  <= rq.install;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Receiver side: random stalls, with calm stretches of steady readiness.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_mode_left == 0)
            begin
                rx_calm      = ($urandom_range(0, 3) == 0);
                rx_mode_left = $urandom_range(100, 1500);
            end
            rx_mode_left--;
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 99) < 25)
                    rx_hold = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        route_result_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_routes.size() == 0)
            begin
                report_mismatch("unexpected item", m_axis_tdata[31:0], '0);
            end
            else
            begin
                w = expected_routes.pop_front();
                if (m_axis_tdata[3:0] !== w.index)
                    report_mismatch("entry_index", ADDR_W'(m_axis_tdata[3:0]),
                                    ADDR_W'(w.index));
                if (m_axis_tuser !== w.action)
                    report_mismatch("action", ADDR_W'(m_axis_tuser), ADDR_W'(w.action));
                if (m_axis_tdata[11:4] !== w.cost)
                    report_mismatch("entry_cost", ADDR_W'(m_axis_tdata[11:4]),
                                    ADDR_W'(w.cost));
                if (m_axis_tdata[43:12] !== w.hop)
                    report_mismatch("entry_next_hop", m_axis_tdata[43:12], w.hop);
                if (m_axis_tdata[75:44] !== w.ifc)
                    report_mismatch("entry_interface", m_axis_tdata[75:44], w.ifc);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        route_req_t    rq;
        route_result_t got;
        int            k;
        int            slot;
        int            r;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        for (k = 0; k < DEPTH; k++)
        begin
            rt_valid[k] = 1'b0;
            rt_dest[k]  = '0;
            rt_hop[k]   = '0;
            rt_ifc[k]   = '0;
            rt_cost[k]  = '0;
        end

        // Inserts into the empty table: neighbor is the destination, saturated
        // costs at both extremes of the address fields, and a local install.
        plan_row(1'b0, 32'h0A00_0001, 8'd200, 32'h0A00_0001, 32'hC0A8_0001);
        plan_want(4'd0, ACT_INSERT, 8'd1, 32'h0A00_0001, 32'hC0A8_0001);
        plan_row(1'b0, 32'hFFFF_FFFF, 8'd255, 32'h0000_0000, 32'hFFFF_FFFF);
        plan_want(4'd1, ACT_INSERT, 8'd255, 32'h0000_0000, 32'hFFFF_FFFF);
        plan_row(1'b0, 32'h0000_0000, 8'd254, 32'hFFFF_FFFF, 32'h0000_0000);
        plan_want(4'd2, ACT_INSERT, 8'd255, 32'hFFFF_FFFF, 32'h0000_0000);
        plan_row(1'b1, 32'h0A00_0002, 8'd255, 32'h1234_5678, 32'hC0A8_0002);
        plan_want(4'd3, ACT_INSERT, 8'd0, 32'hC0A8_0002, 32'hC0A8_0002);
        // Same destination: refresh, cheaper path, dearer path, equal cost,
        // install over it, then cost-zero entry against advertisements.
        plan_row(1'b0, 32'hFFFF_FFFF, 8'd3, 32'h0000_0000, 32'h5555_5555);
        plan_row(1'b0, 32'hFFFF_FFFF, 8'd1, 32'h0B00_0001, 32'hAAAA_AAAA);
        plan_row(1'b0, 32'hFFFF_FFFF, 8'd5, 32'h0B00_0002, 32'h1111_1111);
        plan_row(1'b0, 32'hFFFF_FFFF, 8'd1, 32'h0B00_0003, 32'h2222_2222);
        plan_row(1'b1, 32'hFFFF_FFFF, 8'd9, 32'h0B00_0003, 32'hC0A8_0009);
        plan_row(1'b0, 32'hFFFF_FFFF, 8'd0, 32'h0B00_0001, 32'h3333_3333);
        plan_row(1'b0, 32'hFFFF_FFFF, 8'd255, 32'hC0A8_0009, 32'h4444_4444);
        plan_row(1'b0, 32'h0A00_0001, 8'd255, 32'h0A00_0001, 32'h6666_6666);
        // Fill the remaining slots, then one more destination has no room.
        for (k = 0; k < DEPTH - 4; k++)
            plan_row(k[0], 32'h0A00_0100 + k, 8'(k * 20), 32'h0B00_0000 + (k % 3),
                     32'hC0A8_0100 + k);
        plan_row(1'b0, 32'hDEAD_BEEF, 8'd7, 32'h0B00_0001, 32'hC0A8_0001);
        plan_want(4'd0, ACT_DROPPED, 8'd0, 32'h0, 32'h0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            send_request(plan[i].req, next_tx_gap());
            got = apply_update(plan[i].req);
            expected_routes.insert(expected_routes.size(),
                                   plan[i].fixed ? plan[i].want : got);
        end

        // Random traffic against the full table: mostly known destinations so
        // that the path rules are exercised, with unknown ones that get dropped.
        for (k = 0; k < RAND_ITEMS; k++)
        begin
            slot       = $urandom_range(0, DEPTH - 1);
            rq.install = ($urandom_range(0, 99) < 6);
            r          = $urandom_range(0, 99);
            rq.dest    = (r < 85 && rt_valid[slot]) ? rt_dest[slot] : $urandom;
            r          = $urandom_range(0, 99);
            if (r < 35 && rt_valid[slot])
                rq.nbr = rt_hop[slot];
            else if (r < 80)
                rq.nbr = 32'h0B00_0000 + $urandom_range(0, 3);
            else
                rq.nbr = $urandom;
            r = $urandom_range(0, 99);
            if (r < 60)
                rq.cost = COST_W'($urandom_range(0, 15));
            else if (r < 90)
                rq.cost = COST_W'($urandom_range(0, 255));
            else
                rq.cost = COST_W'($urandom_range(254, 255));
            rq.ifc = $urandom_range(0, 1) ? $urandom : 32'hC0A8_0000 + $urandom_range(0, 7);
            send_request(rq, next_tx_gap());
            got = apply_update(rq);
            expected_routes.insert(expected_routes.size(), got);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_routes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dvtu_pkg.sv
rtl/dvtu_cell.sv
rtl/distance_vector_table_update.sv
rtl/dvtu_checker.sv
tb/sv/tb_distance_vector_table_update.sv
